### design/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Paced FIFO token bucket package
// Field widths, fixed constants, codes and state encoding shared by the block.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int unsigned PTB_RING_BYTES      = 4194304;
    localparam int unsigned PTB_TOKEN_FRAC_BITS = 20;

    localparam int unsigned KIND_W    = 2;
    localparam int unsigned AMOUNT_W  = 16;
    localparam int unsigned DUR_W     = 20;
    localparam int unsigned TIME_W    = 48;
    localparam int unsigned RATE_W    = 32;
    localparam int unsigned SEG_W     = 40;
    localparam int unsigned TOTB_W    = 48;
    localparam int unsigned TOTMS_W   = 40;
    localparam int unsigned DSR_W     = 40;
    localparam int unsigned ELAPSED_W = 19;
    localparam int unsigned PROD_W    = RATE_W + ELAPSED_W;
    localparam int unsigned SEGDIV_W  = TOTB_W + 10;

    // One million is 2^6 times 15625; the odd factor is divided out one
    // 16-bit digit at a time with a reciprocal multiply.
    localparam int unsigned DIG_W    = 16;
    localparam int unsigned REM_W    = 14;
    localparam int unsigned PART_W   = REM_W + DIG_W;
    localparam int unsigned RECIP_W  = 31;
    localparam int unsigned RECIP_SH = 44;
    localparam int unsigned US_SHIFT = 6;

    localparam logic [ELAPSED_W-1:0] HALF_SEC_US = ELAPSED_W'(500000);
    localparam logic [REM_W-1:0]     US_ODD      = REM_W'(15625);
    localparam logic [RECIP_W-1:0]   US_RECIP    = RECIP_W'(1125899907);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_SEG_END = 2'd1,
        KIND_READ    = 2'd2,
        KIND_FINISH  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEG_START,
        ST_SEG_WAIT,
        ST_RD_TIME,
        ST_RD_MUL,
        ST_RD_QUO,
        ST_RD_REM,
        ST_RD_FILL,
        ST_RD_GRANT,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

### design/ptb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Paced FIFO token bucket channels
// Request and result word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptb_in_if;
    logic                            valid;
    logic                            ready;
    logic [ptb_pkg::KIND_W-1:0]      kind;
    logic [ptb_pkg::AMOUNT_W-1:0]    amount;
    logic [ptb_pkg::DUR_W-1:0]       segment_duration_ms;
    logic [ptb_pkg::TIME_W-1:0]      now_us;

    modport source (output valid, kind, amount, segment_duration_ms, now_us, input ready);
    modport sink   (input valid, kind, amount, segment_duration_ms, now_us, output ready);
endinterface

interface ptb_out_if;
    logic                            valid;
    logic                            ready;
    logic [ptb_pkg::AMOUNT_W-1:0]    granted;
    logic                            end_of_stream;
    logic [ptb_pkg::RATE_W-1:0]      rate_bytes_per_s;

    modport source (output valid, granted, end_of_stream, rate_bytes_per_s, input ready);
    modport sink   (input valid, granted, end_of_stream, rate_bytes_per_s, output ready);
endinterface
`default_nettype wire

### design/ptb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Paced FIFO token bucket divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptb_div #(
    parameter int unsigned DIV_W = ptb_pkg::PROD_W + ptb_pkg::PTB_TOKEN_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DIV_W-1:0]            i_dividend,
    input  logic [ptb_pkg::DSR_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [DIV_W-1:0]            o_quotient
);
    import ptb_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic             r_active;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   diff;
    logic             fits;
    logic [DSR_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        diff    = shifted - {1'b0, r_dsr};
        fits    = shifted >= {1'b0, r_dsr};
        n_rem   = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        n_quo   = {r_quo[DIV_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_cnt    <= CNT_W'(DIV_W);
        end else if (r_active) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_active && (r_cnt != '0)) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_active && (r_cnt == '0);
    assign o_quotient = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_active && (r_cnt == CNT_W'(DIV_W))))
        else $error("divider did not load on start");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_start) |=> !r_active)
        else $error("divider stayed active after done");

endmodule
`default_nettype wire

### design/paced_fifo_token_bucket.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Paced FIFO token bucket
// Credit controller for a byte FIFO with a measured-rate token bucket.
// ----------------------------------------------------------------------------
//  Port     Dir  Modport  Word
//  i_in     in   sink     kind, amount, segment_duration_ms, now_us
//  o_out    out  source   granted, end_of_stream, rate_bytes_per_s
//
//  Writes, source finished, zero reads and reads before the rate is known go
//  from acceptance through dispatch straight to the result. A segment end with
//  a duration waits in ST_SEG_WAIT for the bit-serial rate divider. A paced
//  read steps through ST_RD_TIME and ST_RD_MUL, then divides the refill by one
//  million one 16-bit digit at a time in ST_RD_QUO and ST_RD_REM, then runs
//  ST_RD_FILL and ST_RD_GRANT. One word is in work at a time; a new word is
//  accepted while the previous result waits in the output register.
//  Reset is synchronous and clears the byte and time counters, the rate, the bucket and the timestamp.
// ----------------------------------------------------------------------------
module paced_fifo_token_bucket #(
    parameter int unsigned RING_BYTES      = ptb_pkg::PTB_RING_BYTES,
    parameter int unsigned TOKEN_FRAC_BITS = ptb_pkg::PTB_TOKEN_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptb_in_if.sink      i_in,
    ptb_out_if.source   o_out
);
    import ptb_pkg::*;

    localparam int unsigned F      = TOKEN_FRAC_BITS;
    localparam int unsigned OCC_W  = $clog2(RING_BYTES + 1);
    localparam int unsigned CMP_W  = (OCC_W > AMOUNT_W) ? OCC_W : AMOUNT_W;
    localparam int unsigned TOK_W  = RATE_W + F;
    localparam int unsigned DIV_W  = SEGDIV_W;
    localparam int unsigned Y_W    = PROD_W + F - US_SHIFT;
    localparam int unsigned N_DIG  = (Y_W + DIG_W - 1) / DIG_W;
    localparam int unsigned YP_W   = N_DIG * DIG_W;
    localparam int unsigned DCNT_W = $clog2(N_DIG + 1);
    localparam logic [OCC_W-1:0] RING = OCC_W'(RING_BYTES);

    t_state                r_state, n_state;
    logic                  r_out_valid;
    logic [AMOUNT_W-1:0]   r_out_granted;
    logic                  r_out_eos;
    logic [RATE_W-1:0]     r_out_rate;

    t_kind                 r_kind;
    logic [AMOUNT_W-1:0]   r_amount;
    logic [DUR_W-1:0]      r_dur;
    logic [TIME_W-1:0]     r_now;

    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [SEG_W-1:0]      r_seg, n_seg;
    logic [TOTB_W-1:0]     r_totb, n_totb;
    logic [TOTMS_W-1:0]    r_totms, n_totms;
    logic [RATE_W-1:0]     r_rate, n_rate;
    logic [TOK_W-1:0]      r_token, n_token;
    logic [TIME_W-1:0]     r_last, n_last;
    logic                  r_tvalid, n_tvalid;
    logic                  r_fin, n_fin;

    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [YP_W-1:0]       r_ysh, n_ysh;
    logic [YP_W-1:0]       r_qacc, n_qacc;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [DIG_W-1:0]      r_qdig, n_qdig;
    logic [DCNT_W-1:0]     r_dcnt, n_dcnt;
    logic [AMOUNT_W-1:0]   r_res_granted, n_res_granted;
    logic                  r_res_eos, n_res_eos;

    logic                  in_ready;
    logic                  out_free;
    logic                  out_load;
    logic                  div_start;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quotient;
    logic [SEGDIV_W-1:0]   tb_x1000;

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (r_kind)
                    KIND_SEG_END: n_state = (r_dur != '0) ? ST_SEG_START : ST_EMIT;
                    KIND_READ: begin
                        n_state = ((r_amount != '0) && (r_rate != '0)) ? ST_RD_TIME : ST_EMIT;
                    end
                    default: n_state = ST_EMIT;
                endcase
            end
            ST_SEG_START: n_state = ST_SEG_WAIT;
            ST_SEG_WAIT: begin
                if (div_done) n_state = ST_EMIT;
            end
            ST_RD_TIME: n_state = ST_RD_MUL;
            ST_RD_MUL:  n_state = ST_RD_QUO;
            ST_RD_QUO:  n_state = ST_RD_REM;
            ST_RD_REM: begin
                n_state = (r_dcnt == DCNT_W'(1)) ? ST_RD_FILL : ST_RD_QUO;
            end
            ST_RD_FILL:  n_state = ST_RD_GRANT;
            ST_RD_GRANT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        div_start = (r_state == ST_SEG_START);
        out_load  = (r_state == ST_EMIT) && out_free;
    end

    assign i_in.ready = in_ready;

    assign tb_x1000 = {r_totb, 10'b0} - {6'b0, r_totb, 4'b0} - {7'b0, r_totb, 3'b0};

    ptb_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (tb_x1000),
        .i_divisor  (r_totms),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        logic [OCC_W-1:0]          space;
        logic [CMP_W-1:0]          wr_grant;
        logic [RATE_W-1:0]         whole;
        logic [AMOUNT_W-1:0]       budget;
        logic [CMP_W-1:0]          rd_grant;
        logic [SEG_W:0]            seg_sum;
        logic [TOTB_W:0]           totb_sum;
        logic [TOTMS_W:0]          totms_sum;
        logic [TIME_W-1:0]         base;
        logic [TIME_W-1:0]         elapsed;
        logic [TOK_W:0]            tok_sum;
        logic [TOK_W:0]            tok_cap;
        logic [PROD_W-1:0]         prod;
        logic [PART_W-1:0]         part;
        logic [PART_W+RECIP_W-1:0] recip_prod;
        logic [PART_W-1:0]         qd_mul;
        logic [PART_W-1:0]         part_rem;

        n_occ         = r_occ;
        n_seg         = r_seg;
        n_totb        = r_totb;
        n_totms       = r_totms;
        n_rate        = r_rate;
        n_token       = r_token;
        n_last        = r_last;
        n_tvalid      = r_tvalid;
        n_fin         = r_fin;
        n_elapsed     = r_elapsed;
        n_ysh         = r_ysh;
        n_qacc        = r_qacc;
        n_rem         = r_rem;
        n_qdig        = r_qdig;
        n_dcnt        = r_dcnt;
        n_res_granted = r_res_granted;
        n_res_eos     = r_res_eos;

        space    = RING - r_occ;
        wr_grant = (CMP_W'(r_amount) < CMP_W'(space)) ? CMP_W'(r_amount) : CMP_W'(space);
        whole    = r_token[TOK_W-1:F];
        budget   = ((r_state == ST_RD_GRANT) && (RATE_W'(r_amount) > whole))
                 ? whole[AMOUNT_W-1:0] : r_amount;
        rd_grant = (CMP_W'(r_occ) < CMP_W'(budget)) ? CMP_W'(r_occ) : CMP_W'(budget);
        seg_sum   = {1'b0, r_seg} + (SEG_W + 1)'(wr_grant[AMOUNT_W-1:0]);
        totb_sum  = {1'b0, r_totb} + (TOTB_W + 1)'(r_seg);
        totms_sum = {1'b0, r_totms} + (TOTMS_W + 1)'(r_dur);
        base      = r_tvalid ? r_last : r_now;
        elapsed   = (r_now >= base) ? (r_now - base) : '0;
        tok_sum   = {1'b0, r_token} + (TOK_W + 1)'(r_qacc[TOK_W-1:0]);
        tok_cap   = (TOK_W + 1)'(r_rate) << (F - 1);
        prod       = PROD_W'(r_rate) * PROD_W'(r_elapsed);
        part       = {r_rem, r_ysh[YP_W-1 -: DIG_W]};
        recip_prod = (PART_W + RECIP_W)'(part) * (PART_W + RECIP_W)'(US_RECIP);
        qd_mul     = PART_W'(r_qdig) * PART_W'(US_ODD);
        part_rem   = part - qd_mul;

        case (r_state)
            ST_DISPATCH: begin
                n_res_granted = '0;
                n_res_eos     = 1'b0;
                case (r_kind)
                    KIND_WRITE: begin
                        n_res_granted = wr_grant[AMOUNT_W-1:0];
                        n_occ         = r_occ + wr_grant[OCC_W-1:0];
                        n_seg         = seg_sum[SEG_W] ? '1 : seg_sum[SEG_W-1:0];
                    end
                    KIND_SEG_END: begin
                        n_seg = '0;
                        if (r_dur != '0) begin
                            n_totb  = totb_sum[TOTB_W] ? '1 : totb_sum[TOTB_W-1:0];
                            n_totms = totms_sum[TOTMS_W] ? '1 : totms_sum[TOTMS_W-1:0];
                        end
                    end
                    KIND_READ: begin
                        if ((r_amount != '0) && (r_rate == '0)) begin
                            if (r_occ != '0) begin
                                n_res_granted = rd_grant[AMOUNT_W-1:0];
                                n_occ         = r_occ - rd_grant[OCC_W-1:0];
                            end else begin
                                n_res_eos = r_fin;
                            end
                        end
                    end
                    default: n_fin = 1'b1;
                endcase
            end
            ST_SEG_WAIT: begin
                if (div_done) begin
                    n_rate = (|div_quotient[DIV_W-1:RATE_W]) ? '1 : div_quotient[RATE_W-1:0];
                end
            end
            ST_RD_TIME: begin
                n_elapsed = (elapsed > TIME_W'(HALF_SEC_US)) ? HALF_SEC_US
                                                             : elapsed[ELAPSED_W-1:0];
                n_last    = r_now;
                n_tvalid  = 1'b1;
            end
            ST_RD_MUL: begin
                n_ysh  = YP_W'(prod) << (F - US_SHIFT);
                n_qacc = '0;
                n_rem  = '0;
                n_dcnt = DCNT_W'(N_DIG);
            end
            ST_RD_QUO: begin
                n_qdig = recip_prod[RECIP_SH +: DIG_W];
            end
            ST_RD_REM: begin
                n_rem  = part_rem[REM_W-1:0];
                n_ysh  = r_ysh << DIG_W;
                n_qacc = {r_qacc[YP_W-DIG_W-1:0], r_qdig};
                n_dcnt = r_dcnt - DCNT_W'(1);
            end
            ST_RD_FILL: begin
                n_token = (tok_sum > tok_cap) ? tok_cap[TOK_W-1:0] : tok_sum[TOK_W-1:0];
            end
            ST_RD_GRANT: begin
                if (budget != '0) begin
                    if (r_occ != '0) begin
                        n_res_granted = rd_grant[AMOUNT_W-1:0];
                        n_occ         = r_occ - rd_grant[OCC_W-1:0];
                        n_token       = r_token - (TOK_W'(rd_grant[AMOUNT_W-1:0]) << F);
                    end else begin
                        n_res_eos = r_fin;
                    end
                end
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
            r_seg       <= '0;
            r_totb      <= '0;
            r_totms     <= '0;
            r_rate      <= '0;
            r_token     <= '0;
            r_last      <= '0;
            r_tvalid    <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_seg    <= n_seg;
            r_totb   <= n_totb;
            r_totms  <= n_totms;
            r_rate   <= n_rate;
            r_token  <= n_token;
            r_last   <= n_last;
            r_tvalid <= n_tvalid;
            r_fin    <= n_fin;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed     <= n_elapsed;
        r_ysh         <= n_ysh;
        r_qacc        <= n_qacc;
        r_rem         <= n_rem;
        r_qdig        <= n_qdig;
        r_dcnt        <= n_dcnt;
        r_res_granted <= n_res_granted;
        r_res_eos     <= n_res_eos;
        if (in_ready && i_in.valid) begin
            r_kind   <= t_kind'(i_in.kind);
            r_amount <= i_in.amount;
            r_dur    <= i_in.segment_duration_ms;
            r_now    <= i_in.now_us;
        end
        if (out_load) begin
            r_out_granted <= r_res_granted;
            r_out_eos     <= r_res_eos;
            r_out_rate    <= r_rate;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.granted          = r_out_granted;
    assign o_out.end_of_stream    = r_out_eos;
    assign o_out.rate_bytes_per_s = r_out_rate;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= RING)
        else $error("occupancy above ring size");

    a_eos_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eos) |-> (r_out_granted == '0))
        else $error("end of stream with a nonzero grant");

    a_ctrl_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && ((r_kind == KIND_SEG_END) || (r_kind == KIND_FINISH)))
        |-> ((r_res_granted == '0) && !r_res_eos))
        else $error("grant on a segment end or finish word");

endmodule
`default_nettype wire
